[hdl/tced_pkg.sv]
package tced_pkg;

  // one sample word as it arrives
  typedef struct packed {
    logic [31:0] sample_value;
    logic        falling;
    logic [31:0] step_amount;
  } sample_t;

  // one result word
  typedef struct packed {
    logic above_event;
    logic below_event;
    logic change_event;
    logic any_event;
  } result_t;

  // event enable bits as held in the event_enables register
  typedef struct packed {
    logic change;
    logic below;
    logic above;
  } enables_t;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_ABOVE_THRESHOLD  = 2'd0,
    REG_BELOW_THRESHOLD  = 2'd1,
    REG_CHANGE_THRESHOLD = 2'd2,
    REG_EVENT_ENABLES    = 2'd3
  } reg_index_t;

  localparam int unsigned ADDR_WIDTH   = 4;
  localparam int unsigned DATA_WIDTH   = 32;
  localparam int unsigned ENABLE_WIDTH = 3;

endpackage

[hdl/tced_engine.sv]
module tced_engine
  import tced_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [VALUE_WIDTH-1:0] sample_value,
  input  logic                   falling,
  input  logic [VALUE_WIDTH-1:0] step_amount,
  input  logic [VALUE_WIDTH-1:0] above_threshold,
  input  logic [VALUE_WIDTH-1:0] below_threshold,
  input  logic [VALUE_WIDTH-1:0] change_threshold,
  input  enables_t               enables,
  output result_t                result
);

  logic [VALUE_WIDTH-1:0] last_value;
  logic [VALUE_WIDTH-1:0] last_value_next;
  logic [VALUE_WIDTH-1:0] accum;
  logic [VALUE_WIDTH-1:0] accum_next;
  logic [VALUE_WIDTH:0]   sum;
  logic [VALUE_WIDTH-1:0] sum_sat;
  logic                   reached;
  logic                   ev_above;
  logic                   ev_below;
  logic                   ev_change;
  logic                   ev_any;

  always_comb begin
    ev_above = !falling && (last_value < above_threshold) &&
               (sample_value >= above_threshold) && enables.above;
    ev_below = falling && (last_value > below_threshold) &&
               (sample_value <= below_threshold) && enables.below;

    // saturating add of the step
    sum     = {1'b0, accum} + {1'b0, step_amount};
    sum_sat = sum[VALUE_WIDTH] ? {VALUE_WIDTH{1'b1}} : sum[VALUE_WIDTH-1:0];
    reached = (change_threshold <= sum_sat);

    ev_change  = reached && enables.change;
    ev_any     = ev_above || ev_below || ev_change;
    accum_next = reached ? '0 : sum_sat;
    last_value_next = ev_any ? sample_value : last_value;

    result.above_event  = ev_above;
    result.below_event  = ev_below;
    result.change_event = ev_change;
    result.any_event    = ev_any;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_value <= '0;
      accum      <= '0;
    end else if (take) begin
      last_value <= last_value_next;
      accum      <= accum_next;
    end
  end

endmodule

[hdl/threshold_crossing_event_detector.sv]
// Threshold crossing event detector. Each sample word (sample_value, falling,
// step_amount) yields exactly one result word with above, below, change and
// any event flags. A rising sample flags above when the value at the last
// reported event lay under above_threshold and the sample is at or over it; a
// falling sample flags below in the mirror case against below_threshold. The
// step is added, saturating, to an accumulator that clears and flags change
// once it reaches change_threshold. Each flag is gated by its bit in
// event_enables, and any flag makes the sample the new last reported value.
// Only the low VALUE_WIDTH bits of samples, steps and thresholds are used.
// The block takes one sample word every cycle while sample_stall is low; the
// result is registered in an output register, or in one skid register behind
// it while the output is stalled, so sample_stall rises only when two results
// wait behind a stalled output. Registers sit at byte addresses 0, 4, 8 and 12
// in list order and should be written only while no word is in flight.
module threshold_crossing_event_detector
  import tced_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  logic [VALUE_WIDTH-1:0] above_threshold;
  logic [VALUE_WIDTH-1:0] below_threshold;
  logic [VALUE_WIDTH-1:0] change_threshold;
  enables_t               event_enables;
  reg_index_t             reg_sel;
  logic                   reg_write;

  logic    take;
  logic    out_free;
  logic    skid_valid;
  result_t skid;
  result_t eval_result;

  // configuration port
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[ADDR_WIDTH-1:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      above_threshold  <= '0;
      below_threshold  <= '0;
      change_threshold <= '0;
      event_enables    <= '0;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_ABOVE_THRESHOLD:  above_threshold  <= pwdata[VALUE_WIDTH-1:0];
        REG_BELOW_THRESHOLD:  below_threshold  <= pwdata[VALUE_WIDTH-1:0];
        REG_CHANGE_THRESHOLD: change_threshold <= pwdata[VALUE_WIDTH-1:0];
        REG_EVENT_ENABLES:    event_enables    <= enables_t'(pwdata[ENABLE_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ABOVE_THRESHOLD:  prdata = DATA_WIDTH'(above_threshold);
      REG_BELOW_THRESHOLD:  prdata = DATA_WIDTH'(below_threshold);
      REG_CHANGE_THRESHOLD: prdata = DATA_WIDTH'(change_threshold);
      REG_EVENT_ENABLES:    prdata = DATA_WIDTH'(event_enables);
      default:              prdata = '0;
    endcase
  end

  // sample side
  assign sample_stall = skid_valid;
  assign take         = sample_valid && !skid_valid;

  tced_engine #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .sample_value     (sample.sample_value[VALUE_WIDTH-1:0]),
    .falling          (sample.falling),
    .step_amount      (sample.step_amount[VALUE_WIDTH-1:0]),
    .above_threshold  (above_threshold),
    .below_threshold  (below_threshold),
    .change_threshold (change_threshold),
    .enables          (event_enables),
    .result           (eval_result)
  );

  // output register with one skid word behind it
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result       <= skid;
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result       <= eval_result;
        result_valid <= take;
      end
    end else if (take) begin
      skid       <= eval_result;
      skid_valid <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid word held with empty output register");

  a_any_is_or: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.any_event ==
                      (result.above_event || result.below_event || result.change_event)))
    else $error("any_event does not match the event flags");

  a_direction_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.above_event && result.below_event))
    else $error("above and below flagged for one word");
`endif

endmodule

[test/tced_checker.sv]
`timescale 1ns / 100ps

module tced_checker
  import tced_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  input  logic                  sample_stall,
  input  sample_t               sample,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output int                    events_pending,
  output int                    mismatch_count
);

  localparam logic [31:0] VALUE_MASK = 32'((64'd1 << VALUE_WIDTH) - 64'd1);

  // register copies
  logic [31:0] above_level;
  logic [31:0] below_level;
  logic [31:0] change_level;
  enables_t    enabled;

  // detector state
  logic [31:0] last_event_value;
  logic [31:0] change_sum;

  result_t expected_events[$];

  task automatic report_mismatch(input string what, input result_t got, input result_t want);
    if (mismatch_count < 200)
      $display("mismatch at %0t ns: %s, got %b expected %b", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // one compare-and-accumulate step, updates the detector state
  function automatic result_t detect_crossing(input sample_t w);
    logic [31:0] value;
    logic [31:0] step;
    logic [32:0] sum;
    result_t     r;
    value = w.sample_value & VALUE_MASK;
    step  = w.step_amount & VALUE_MASK;
    r     = '0;
    if (w.falling) begin
      r.below_event = enabled.below && last_event_value > below_level && value <= below_level;
    end else begin
      r.above_event = enabled.above && last_event_value < above_level && value >= above_level;
    end
    sum = {1'b0, change_sum} + {1'b0, step};
    if (sum > {1'b0, VALUE_MASK})
      sum = {1'b0, VALUE_MASK};
    change_sum = sum[31:0];
    if (change_level <= change_sum) begin
      change_sum     = '0;
      r.change_event = enabled.change;
    end
    r.any_event = r.above_event || r.below_event || r.change_event;
    if (r.any_event)
      last_event_value = value;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      above_level      = '0;
      below_level      = '0;
      change_level     = '0;
      enabled          = '0;
      last_event_value = '0;
      change_sum       = '0;
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[3:2]))
          REG_ABOVE_THRESHOLD:  above_level  = pwdata & VALUE_MASK;
          REG_BELOW_THRESHOLD:  below_level  = pwdata & VALUE_MASK;
          REG_CHANGE_THRESHOLD: change_level = pwdata & VALUE_MASK;
          REG_EVENT_ENABLES:    enabled      = enables_t'(pwdata[ENABLE_WIDTH-1:0]);
          default: ;
        endcase
      end
      // retire before predicting: a result never belongs to a word taken at the same edge
      if (result_valid && !result_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch("result word with nothing expected", result, '0);
        end else begin
          want = expected_events.pop_front();
          if (result.above_event !== want.above_event)
            report_mismatch("above_event", result, want);
          if (result.below_event !== want.below_event)
            report_mismatch("below_event", result, want);
          if (result.change_event !== want.change_event)
            report_mismatch("change_event", result, want);
          if (result.any_event !== want.any_event)
            report_mismatch("any_event", result, want);
        end
      end
      if (sample_valid && !sample_stall)
        expected_events.push_back(detect_crossing(sample));
    end
    events_pending <= expected_events.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import tced_pkg::*;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam int          ITEM_GOAL   = 1350;
  localparam int          CALM_FROM   = 1200;
  localparam int          CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  int          events_pending;
  int          mismatch_count;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          stall_hold = 0;
  logic        calm = 1'b0;
  logic [31:0] above_cfg = '0;
  logic [31:0] below_cfg = '0;

  always #10 clk = ~clk;

  threshold_crossing_event_detector #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tced_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .events_pending(events_pending), .mismatch_count(mismatch_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall bursts between free-running stretches
  always @(posedge clk) begin
    if (rst || calm) begin
      result_stall <= 1'b0;
      stall_hold   <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (result_stall) begin
      result_stall <= 1'b0;
      stall_hold   <= $urandom_range(0, 30);
    end else begin
      result_stall <= 1'b1;
      stall_hold   <= $urandom_range(0, 17);
    end
  end

  task automatic send_word(input logic [31:0] value, input logic down, input logic [31:0] step);
    if (!calm && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    sample_valid         <= 1'b1;
    sample.sample_value  <= value;
    sample.falling       <= down;
    sample.step_amount   <= step;
    do @(posedge clk); while (sample_stall);
    items_sent++;
    if (items_sent >= CALM_FROM)
      calm = 1'b1;
  endtask

  // stop sending and wait until every result word has come back
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (events_pending != 0);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input logic [31:0] above, input logic [31:0] below,
                              input logic [31:0] change, input logic [2:0] enables);
    above_cfg = above;
    below_cfg = below;
    write_reg(REG_ABOVE_THRESHOLD, above);
    write_reg(REG_BELOW_THRESHOLD, below);
    write_reg(REG_CHANGE_THRESHOLD, change);
    // upper bits of the enables word are don't-care
    write_reg(REG_EVENT_ENABLES, {29'($urandom), enables});
  endtask

  function automatic logic [31:0] near_level(input logic [31:0] level);
    return level + 32'($urandom_range(0, 16)) - 32'd8;
  endfunction

  task automatic random_config();
    logic [31:0] above;
    logic [31:0] below;
    logic [31:0] change;
    logic [2:0]  enables;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      below = $urandom;
      above = below + 32'($urandom_range(0, 2000));
    end else if (pick < 8) begin
      below = $urandom;
      above = $urandom;
    end else if (pick == 8) begin
      below = '0;
      above = ALL_ONES;
    end else begin
      below = ALL_ONES;
      above = '0;
    end
    pick = $urandom_range(0, 9);
    if (pick < 6)       change = $urandom_range(1, 400);
    else if (pick == 6) change = '0;
    else if (pick == 7) change = ALL_ONES;
    else                change = $urandom;
    enables = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
    apply_config(above, below, change, enables);
  endtask

  // mostly samples close to the level their direction can cross
  task automatic random_item();
    logic [31:0] value;
    logic [31:0] step;
    logic        down;
    int          pick;
    down = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 6)       value = near_level(down ? below_cfg : above_cfg);
    else if (pick < 8)  value = $urandom;
    else if (pick == 8) value = '0;
    else                value = ALL_ONES;
    pick = $urandom_range(0, 9);
    if (pick < 7)      step = $urandom_range(0, 64);
    else if (pick < 9) step = $urandom;
    else               step = ALL_ONES;
    send_word(value, down, step);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // basic crossings in both directions, accumulator reaching its level
    apply_config(32'd1000, 32'd500, 32'd300, 3'b111);
    send_word(32'd999, 1'b0, 32'd0);
    send_word(32'd1000, 1'b0, 32'd100);
    send_word(32'd2000, 1'b0, 32'd0);
    send_word(32'd501, 1'b1, 32'd0);
    send_word(32'd500, 1'b1, 32'd200);
    send_word(32'd0, 1'b1, 32'd0);
    send_word(ALL_ONES, 1'b0, ALL_ONES);
    send_word(32'd0, 1'b1, ALL_ONES);
    settle();

    // extreme levels, accumulator saturating at full scale
    apply_config(ALL_ONES, 32'd0, ALL_ONES, 3'b111);
    send_word(ALL_ONES - 32'd1, 1'b0, 32'h8000_0000);
    send_word(ALL_ONES, 1'b0, 32'h8000_0000);
    send_word(32'd0, 1'b1, 32'd0);
    send_word(32'd0, 1'b1, ALL_ONES);
    settle();

    // crossings impossible, zero change level fires every word
    apply_config(32'd0, ALL_ONES, 32'd0, 3'b100);
    send_word(ALL_ONES, 1'b0, 32'd0);
    send_word(32'd0, 1'b1, 32'd5);
    send_word(32'd123, 1'b1, 32'd0);
    settle();

    // everything disabled: accumulator still clears, nothing flagged
    apply_config(32'd200, 32'd100, 32'd0, 3'b000);
    send_word(32'd300, 1'b0, 32'd7);
    send_word(32'd50, 1'b1, 32'd0);
    settle();

    // crossings only, change disabled
    apply_config(32'd200, 32'd100, 32'd50, 3'b011);
    send_word(32'd300, 1'b0, 32'd49);
    send_word(32'd50, 1'b1, 32'd1);
    send_word(32'd50, 1'b0, 32'd60);
    send_word(32'd250, 1'b1, 32'd0);

    while (items_sent < ITEM_GOAL) begin
      settle();
      random_config();
      repeat ($urandom_range(40, 120)) random_item();
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[threshold_crossing_event_detector.f]
hdl/tced_pkg.sv
hdl/tced_engine.sv
hdl/threshold_crossing_event_detector.sv
test/tced_checker.sv
test/tb_top.sv
